/* rtl/core/bamc_pkg.sv */
// Package: shared constants and types of the adjacency matrix closure unit.
package bamc_pkg;

   localparam int MAX_V = 32;
   localparam int IDX_W = $clog2(MAX_V);
   localparam int CNT_W = $clog2(MAX_V + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [MAX_V-1:0] row_type;

   typedef enum logic [2:0] {
      CMD_ADD       = 3'd0,
      CMD_REMOVE    = 3'd1,
      CMD_QUERY     = 3'd2,
      CMD_TRANSPOSE = 3'd3,
      CMD_CLOSURE   = 3'd4,
      CMD_SCAN      = 3'd5
   } cmd_type;

   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_UNDIRECTED   = 1'b1;

endpackage

/* rtl/core/bamc_chan_if.sv */
// Interfaces: request and response channels of the adjacency matrix closure unit.
interface bamc_req_if;
   import bamc_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   idx_type     src_vertex;
   idx_type     dst_vertex;
   modport source (output valid, cmd, src_vertex, dst_vertex, input ready);
   modport sink   (input valid, cmd, src_vertex, dst_vertex, output ready);
endinterface

interface bamc_rsp_if;
   import bamc_pkg::*;
   logic        valid;
   logic        ready;
   logic        status;
   logic        edge_present;
   cnt_type     neighbor_index;
   modport source (output valid, status, edge_present, neighbor_index, input ready);
   modport sink   (input valid, status, edge_present, neighbor_index, output ready);
endinterface

/* rtl/core/bit_adjacency_matrix_closure_unit.sv */
// Top level: one-bit adjacency matrix with edge edit, query, scan, transpose and closure.
//
// Usage: a command beat on req_chan (cmd, src_vertex, dst_vertex) gives exactly one
// response beat on rsp_chan (status, edge_present, neighbor_index). Both channels use
// valid/ready; a beat moves when both are high. csr_we/csr_index/csr_wdata write the
// vertex count (index 0) and the directed flag (index 1); the user must write them
// only while the unit is idle, as the unit does not enforce it. The matrix lives in one
// 32-row memory with a single read and a single write port, read data registered;
// edits, transpose and closure are read-modify-writes over rows; query and scan only
// read. Out-of-range and no-op commands answer in the cycle after acceptance; query
// and scan answer after the row read; add and remove also rewrite the destination row
// when undirected. Transpose and closure are bound by the single memory read port.
// One command is in flight at a time; req_chan.ready rises again as the response
// register frees, so a new beat can enter while the last response is being taken.
// Reset clears all row valid bits, so the matrix reads as zero at once, and sets the
// count to 32 and the directed flag. A stalled receiver holds the response register
// and blocks the next command.
module bit_adjacency_matrix_closure_unit (
   input  logic               clock,
   input  logic               reset,
   bamc_req_if.sink           req_chan,
   bamc_rsp_if.source         rsp_chan,
   input  logic               csr_we,
   input  logic               csr_index,
   input  bamc_pkg::cnt_type  csr_wdata
);
   import bamc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ROW, S_ROW2, T_ROWI, T_ROWJ, T_WRI, C_ROWK, C_ROWI
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   idx_type   src_ff, src_in, dst_ff, dst_in;
   idx_type   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   cnt_type   cnt_ff, cnt_in;
   logic      dir_ff, dir_in;
   row_type   row_ff, row_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      status_ff, status_in, present_ff, present_in;
   cnt_type   nbr_ff, nbr_in;
   cnt_type   vcount_ff;
   logic      undir_off_ff;

   // memory and its port signals
   row_type   mem [MAX_V];
   logic [MAX_V-1:0] valid_ff;
   row_type   mem_q_ff;
   logic      mem_qv_ff;
   logic      mem_we, mem_re;
   idx_type   mem_waddr, mem_raddr;
   row_type   mem_wdata;
   row_type   rowdata;

   logic      req_fire, rsp_fire;
   cnt_type   n_eff;
   logic      in_range;
   row_type   mask, cand, wr;
   cnt_type   scan_idx;

   assign rowdata  = mem_qv_ff ? mem_q_ff : '0;
   assign n_eff    = (vcount_ff > cnt_type'(MAX_V)) ? cnt_type'(MAX_V) : vcount_ff;
   assign in_range = ({1'b0, req_chan.src_vertex} < n_eff) &&
                     ({1'b0, req_chan.dst_vertex} < n_eff);
   assign mask     = row_type'(((MAX_V+1)'(1) << cnt_ff) - (MAX_V+1)'(1));
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.edge_present   = present_ff;
   assign rsp_chan.neighbor_index = nbr_ff;

   // find first set column at or after the start
   always_comb begin
      cand     = rowdata & mask & (~row_type'(0) << dst_ff);
      scan_idx = cnt_ff;
      for (int b = MAX_V - 1; b >= 0; b--) begin
         if (cand[b]) scan_idx = cnt_type'(b);
      end
   end

   // sequence commands over memory rows
   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; src_in = src_ff; dst_in = dst_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; cnt_in = cnt_ff; dir_in = dir_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      status_in = status_ff; present_in = present_ff; nbr_in = nbr_ff;
      mem_we = 1'b0; mem_re = 1'b0; mem_waddr = '0; mem_raddr = '0; mem_wdata = '0;
      wr = rowdata;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in = cmd_type'(req_chan.cmd);
               src_in = req_chan.src_vertex;
               dst_in = req_chan.dst_vertex;
               cnt_in = n_eff;
               dir_in = undir_off_ff;
               rsp_valid_in = 1'b1; status_in = 1'b0; present_in = 1'b0; nbr_in = '0;
               case (req_chan.cmd) inside
                  CMD_ADD, CMD_REMOVE, CMD_QUERY, CMD_SCAN: begin
                     if (in_range) begin
                        rsp_valid_in = 1'b0;
                        mem_re = 1'b1; mem_raddr = req_chan.src_vertex;
                        state_in = S_ROW;
                     end else begin
                        status_in = 1'b1;
                        if (req_chan.cmd == CMD_SCAN) nbr_in = n_eff;
                     end
                  end
                  CMD_TRANSPOSE: begin
                     if (undir_off_ff && n_eff >= cnt_type'(2)) begin
                        rsp_valid_in = 1'b0;
                        i_in = '0; mem_re = 1'b1; mem_raddr = '0;
                        state_in = T_ROWI;
                     end
                  end
                  CMD_CLOSURE: begin
                     if (n_eff != '0) begin
                        rsp_valid_in = 1'b0;
                        k_in = '0; mem_re = 1'b1; mem_raddr = '0;
                        state_in = C_ROWK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ROW: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1; status_in = 1'b0; present_in = 1'b0; nbr_in = '0;
            case (cmd_ff)
               CMD_QUERY: present_in = rowdata[dst_ff];
               CMD_SCAN:  nbr_in = scan_idx;
               default: begin
                  wr[dst_ff] = (cmd_ff == CMD_ADD);
                  mem_we = 1'b1; mem_waddr = src_ff; mem_wdata = wr;
                  if (!dir_ff) begin
                     rsp_valid_in = 1'b0;
                     mem_re = 1'b1; mem_raddr = dst_ff;
                     state_in = S_ROW2;
                  end
               end
            endcase
         end
         S_ROW2: begin
            wr[src_ff] = (cmd_ff == CMD_ADD);
            mem_we = 1'b1; mem_waddr = dst_ff; mem_wdata = wr;
            rsp_valid_in = 1'b1; status_in = 1'b0; present_in = 1'b0; nbr_in = '0;
            state_in = S_IDLE;
         end
         T_ROWI: begin
            row_in = rowdata;
            j_in = i_ff + idx_type'(1);
            mem_re = 1'b1; mem_raddr = i_ff + idx_type'(1);
            state_in = T_ROWJ;
         end
         T_ROWJ: begin
            // swap cell (i,j) with cell (j,i)
            wr[i_ff] = row_ff[j_ff];
            mem_we = 1'b1; mem_waddr = j_ff; mem_wdata = wr;
            row_in[j_ff] = rowdata[i_ff];
            if ({1'b0, j_ff} + cnt_type'(1) < cnt_ff) begin
               j_in = j_ff + idx_type'(1);
               mem_re = 1'b1; mem_raddr = j_ff + idx_type'(1);
            end else begin
               state_in = T_WRI;
            end
         end
         T_WRI: begin
            mem_we = 1'b1; mem_waddr = i_ff; mem_wdata = row_ff;
            if ({1'b0, i_ff} + cnt_type'(2) < cnt_ff) begin
               i_in = i_ff + idx_type'(1);
               mem_re = 1'b1; mem_raddr = i_ff + idx_type'(1);
               state_in = T_ROWI;
            end else begin
               rsp_valid_in = 1'b1; status_in = 1'b0; present_in = 1'b0; nbr_in = '0;
               state_in = S_IDLE;
            end
         end
         C_ROWK: begin
            row_in = rowdata & mask;
            i_in = '0; mem_re = 1'b1; mem_raddr = '0;
            state_in = C_ROWI;
         end
         C_ROWI: begin
            // merge pivot row into every row that reaches the pivot
            if (rowdata[k_ff]) begin
               mem_we = 1'b1; mem_waddr = i_ff; mem_wdata = rowdata | row_ff;
            end
            if ({1'b0, i_ff} + cnt_type'(1) < cnt_ff) begin
               i_in = i_ff + idx_type'(1);
               mem_re = 1'b1; mem_raddr = i_ff + idx_type'(1);
            end else if ({1'b0, k_ff} + cnt_type'(1) < cnt_ff) begin
               k_in = k_ff + idx_type'(1);
               mem_re = 1'b1; mem_raddr = k_ff + idx_type'(1);
               state_in = C_ROWK;
            end else begin
               rsp_valid_in = 1'b1; status_in = 1'b0; present_in = 1'b0; nbr_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vcount_ff <= cnt_type'(MAX_V);
         undir_off_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == CSR_VERTEX_COUNT) vcount_ff <= csr_wdata;
            else undir_off_ff <= csr_wdata[0];
         end
      end
      cmd_ff <= cmd_in; src_ff <= src_in; dst_ff <= dst_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      cnt_ff <= cnt_in; dir_ff <= dir_in; row_ff <= row_in;
      status_ff <= status_in; present_ff <= present_in; nbr_ff <= nbr_in;
   end

   // row valid bits: an unwritten row reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[mem_waddr] <= 1'b1;
      end
   end

   // matrix memory with write-to-read forwarding
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) begin
         if (mem_we && mem_waddr == mem_raddr) begin
            mem_q_ff <= mem_wdata;
            mem_qv_ff <= 1'b1;
         end else begin
            mem_q_ff <= mem[mem_raddr];
            mem_qv_ff <= valid_ff[mem_raddr];
         end
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff || state_ff != S_IDLE))
      else $error("accepted command left no trace");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_we)
      else $error("memory written while idle");
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !rsp_valid_ff)
      else $error("response pending during a multi-cycle command");
endmodule
